@@ rtl/rv64x_pkg.sv @@
// Shared types and constants for the RV64I subset execute block.
`timescale 1ns / 1ps
package rv64x_pkg;

  localparam int unsigned RegCount   = 32;
  localparam logic [63:0] StartReset = 64'd4096;

  // Major opcodes
  localparam logic [6:0] OpcLui    = 7'h37;
  localparam logic [6:0] OpcJal    = 7'h6F;
  localparam logic [6:0] OpcJalr   = 7'h67;
  localparam logic [6:0] OpcBranch = 7'h63;
  localparam logic [6:0] OpcLoad   = 7'h03;
  localparam logic [6:0] OpcStore  = 7'h23;
  localparam logic [6:0] OpcOpImm  = 7'h13;
  localparam logic [6:0] OpcOp     = 7'h33;
  localparam logic [6:0] OpcImm32  = 7'h1B;
  localparam logic [6:0] OpcOp32   = 7'h3B;

  // funct7 and funct6 codes
  localparam logic [6:0] F7Base = 7'h00;
  localparam logic [6:0] F7Alt  = 7'h20;
  localparam logic [5:0] F6Sra  = 6'h10;

  // Item kinds
  localparam logic ItemInst = 1'b0;
  localparam logic ItemLoad = 1'b1;

  // Memory access kinds
  localparam logic [1:0] AccNone  = 2'd0;
  localparam logic [1:0] AccRead  = 2'd1;
  localparam logic [1:0] AccWrite = 2'd2;

  // Load result formats
  localparam logic [1:0] FmtLw  = 2'd0;
  localparam logic [1:0] FmtLd  = 2'd1;
  localparam logic [1:0] FmtLbu = 2'd2;

  // One result beat
  typedef struct packed {
    logic [63:0] next_pc;
    logic [1:0]  access_kind;
    logic [1:0]  access_size;
    logic [63:0] access_address;
    logic [63:0] store_data;
    logic        fault;
  } result_t;

  function automatic logic [63:0] sx32(input logic [31:0] v);
    sx32 = {{32{v[31]}}, v};
  endfunction

endpackage

@@ rtl/rv64i_subset_execute_top.sv @@
// Top level of the RV64I subset execute block: register file RAMs, execute stage, output beat.
`timescale 1ns / 1ps
// One item is accepted per cycle with no bubbles while the receiver takes each result
// beat, so an instruction stream runs at one item per clock. The two source operands of
// an item are read from the register file at the edge that accepts it (two synchronous
// RAM copies, one per read port); the item then executes and, once the output register is
// free, writes back and lands in it as a result beat. A result written back in the same
// cycle that a younger item reads the register file is forwarded. The register file reads
// as zero until an entry is first written, so no clearing pass is needed after reset.
// Writing start_address also loads the program counter; do so only while the block is idle.
module rv64i_subset_execute_top
  import rv64x_pkg::*;
#(
  parameter int unsigned REGISTER_COUNT = RegCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] start_address_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        item_kind_i,
  input  logic [31:0] instruction_word_i,
  input  logic [63:0] load_data_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] next_pc_o,
  output logic [1:0]  access_kind_o,
  output logic [1:0]  access_size_o,
  output logic [63:0] access_address_o,
  output logic [63:0] store_data_o,
  output logic        fault_o
);

  localparam int unsigned AW = $clog2(REGISTER_COUNT);

  // architectural state
  logic [63:0]             pc_q, pc_d;
  logic                    ld_pend_q, ld_pend_d;
  logic [AW-1:0]           ld_tgt_q, ld_tgt_d;
  logic [1:0]              ld_fmt_q, ld_fmt_d;
  logic [REGISTER_COUNT-1:0] rf_valid_q;

  // execute stage
  logic        s1_valid_q;
  logic        s1_kind_q;
  logic [31:0] s1_inst_q;
  logic [63:0] s1_ldata_q;
  logic        fwd1_q, fwd2_q;
  logic [63:0] fwdv_q;

  // output beat
  logic    out_valid_q;
  result_t out_q, res;

  logic        in_fire, s1_fire;
  logic        wb_en;
  logic [AW-1:0] wb_addr;
  logic [63:0] wb_data;
  logic [AW-1:0] in_rs1, in_rs2;
  logic [63:0] rdata1, rdata2;

  assign cfg_ready_o = 1'b1;
  assign s1_fire     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_fire;
  assign in_fire     = in_valid_i && in_ready_o;
  assign in_rs1      = instruction_word_i[15+AW-1:15];
  assign in_rs2      = instruction_word_i[20+AW-1:20];

  // Register file, one copy per read port
  rv64x_ram #(.Width(64), .Depth(REGISTER_COUNT)) u_rf_a (
    .clk_i  (clk_i),
    .we_i   (wb_en && s1_fire),
    .waddr_i(wb_addr),
    .wdata_i(wb_data),
    .re_i   (in_fire),
    .raddr_i(in_rs1),
    .rdata_o(rdata1)
  );

  rv64x_ram #(.Width(64), .Depth(REGISTER_COUNT)) u_rf_b (
    .clk_i  (clk_i),
    .we_i   (wb_en && s1_fire),
    .waddr_i(wb_addr),
    .wdata_i(wb_data),
    .re_i   (in_fire),
    .raddr_i(in_rs2),
    .rdata_o(rdata2)
  );

  // Decode fields of the held instruction
  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [AW-1:0] rd, rs1, rs2;
  logic [63:0] a, b, immi, imms, immb, immj, sum_ai;
  logic [5:0]  sh;
  logic [4:0]  shw;
  logic [31:0] w_sra;

  assign op   = s1_inst_q[6:0];
  assign f3   = s1_inst_q[14:12];
  assign f7   = s1_inst_q[31:25];
  assign rd   = s1_inst_q[7+AW-1:7];
  assign rs1  = s1_inst_q[15+AW-1:15];
  assign rs2  = s1_inst_q[20+AW-1:20];
  assign immi = {{52{s1_inst_q[31]}}, s1_inst_q[31:20]};
  assign imms = {{52{s1_inst_q[31]}}, s1_inst_q[31:25], s1_inst_q[11:7]};
  assign immb = {{51{s1_inst_q[31]}}, s1_inst_q[31], s1_inst_q[7], s1_inst_q[30:25],
                 s1_inst_q[11:8], 1'b0};
  assign immj = {{43{s1_inst_q[31]}}, s1_inst_q[31], s1_inst_q[19:12], s1_inst_q[20],
                 s1_inst_q[30:21], 1'b0};

  // Pick operands: forwarded write, then RAM if the entry was ever written, else zero
  always_comb begin
    if (fwd1_q) begin
      a = fwdv_q;
    end else if (rs1 != '0 && rf_valid_q[rs1]) begin
      a = rdata1;
    end else begin
      a = '0;
    end
    if (fwd2_q) begin
      b = fwdv_q;
    end else if (rs2 != '0 && rf_valid_q[rs2]) begin
      b = rdata2;
    end else begin
      b = '0;
    end
  end

  assign sum_ai = a + immi;
  assign sh     = s1_inst_q[25:20];
  assign shw    = (op == OpcImm32) ? s1_inst_q[24:20] : b[4:0];
  assign w_sra  = $signed(a[31:0]) >>> shw;

  // Execute one item
  logic        ok, wr, take;
  logic [63:0] val, nxt, addr, data;
  logic [1:0]  kind, size, fmt;

  always_comb begin
    ok   = 1'b1;
    wr   = 1'b0;
    take = 1'b0;
    val  = '0;
    nxt  = pc_q + 64'd4;
    addr = '0;
    data = '0;
    kind = AccNone;
    size = 2'd0;
    fmt  = FmtLw;
    unique case (op)
      OpcLui: begin
        wr  = 1'b1;
        val = sx32({s1_inst_q[31:12], 12'h000});
      end
      OpcJal: begin
        wr  = 1'b1;
        val = pc_q + 64'd4;
        nxt = pc_q + immj;
      end
      OpcJalr: begin
        if (f3 != 3'd0) begin
          ok = 1'b0;
        end else begin
          wr  = 1'b1;
          val = pc_q + 64'd4;
          nxt = {sum_ai[63:1], 1'b0};
        end
      end
      OpcBranch: begin
        unique case (f3)
          3'd0: take = (a == b);
          3'd1: take = (a != b);
          3'd5: take = ($signed(a) >= $signed(b));
          3'd6: take = (a < b);
          3'd7: take = (a >= b);
          default: ok = 1'b0;
        endcase
        if (take) begin
          nxt = pc_q + immb;
        end
      end
      OpcLoad: begin
        kind = AccRead;
        addr = sum_ai;
        unique case (f3)
          3'd2: begin fmt = FmtLw;  size = 2'd2; end
          3'd3: begin fmt = FmtLd;  size = 2'd3; end
          3'd4: begin fmt = FmtLbu; size = 2'd0; end
          default: ok = 1'b0;
        endcase
      end
      OpcStore: begin
        if (f3[2]) begin
          ok = 1'b0;
        end else begin
          kind = AccWrite;
          size = f3[1:0];
          data = b;
          addr = a + imms;
        end
      end
      OpcOpImm: begin
        wr = 1'b1;
        unique case (f3)
          3'd0: val = sum_ai;
          3'd1: begin
            if (s1_inst_q[31:26] != 6'd0) ok = 1'b0;
            else val = a << sh;
          end
          3'd2: val = {63'd0, $signed(a) < $signed(immi)};
          3'd3: val = {63'd0, a < immi};
          3'd4: val = a ^ immi;
          3'd5: begin
            if (s1_inst_q[31:26] == 6'd0) val = a >> sh;
            else if (s1_inst_q[31:26] == F6Sra) val = $signed(a) >>> sh;
            else ok = 1'b0;
          end
          3'd6: val = a | immi;
          3'd7: val = a & immi;
          default: ok = 1'b0;
        endcase
      end
      OpcOp: begin
        wr = 1'b1;
        if (f7 != F7Base) begin
          ok = 1'b0;
        end else begin
          unique case (f3)
            3'd0: val = a + b;
            3'd3: val = {63'd0, a < b};
            3'd4: val = a ^ b;
            3'd6: val = a | b;
            3'd7: val = a & b;
            default: ok = 1'b0;
          endcase
        end
      end
      OpcImm32, OpcOp32: begin
        wr = 1'b1;
        if (f3 == 3'd0) begin
          if (op == OpcImm32) val = sx32(sum_ai[31:0]);
          else if (f7 == F7Base) val = sx32(a[31:0] + b[31:0]);
          else if (f7 == F7Alt) val = sx32(a[31:0] - b[31:0]);
          else ok = 1'b0;
        end else if (f3 == 3'd1 && f7 == F7Base) begin
          val = sx32(a[31:0] << shw);
        end else if (f3 == 3'd5 && f7 == F7Base) begin
          val = sx32(a[31:0] >> shw);
        end else if (f3 == 3'd5 && f7 == F7Alt) begin
          val = sx32(w_sra);
        end else begin
          ok = 1'b0;
        end
      end
      default: ok = 1'b0;
    endcase
  end

  // Resolve the item into a result, state update and write-back
  logic [63:0] ld_val;

  always_comb begin
    unique case (ld_fmt_q)
      FmtLw:   ld_val = sx32(s1_ldata_q[31:0]);
      FmtLbu:  ld_val = {56'd0, s1_ldata_q[7:0]};
      default: ld_val = s1_ldata_q;
    endcase
  end

  always_comb begin
    res       = '0;
    res.next_pc = pc_q;
    pc_d      = pc_q;
    ld_pend_d = ld_pend_q;
    ld_tgt_d  = ld_tgt_q;
    ld_fmt_d  = ld_fmt_q;
    wb_en     = 1'b0;
    wb_addr   = rd;
    wb_data   = val;
    if (s1_kind_q == ItemLoad) begin
      if (!ld_pend_q) begin
        res.fault = 1'b1;
      end else begin
        wb_en     = (ld_tgt_q != '0);
        wb_addr   = ld_tgt_q;
        wb_data   = ld_val;
        ld_pend_d = 1'b0;
      end
    end else if (ld_pend_q || !ok) begin
      res.fault = 1'b1;
    end else begin
      wb_en              = wr && (rd != '0);
      pc_d               = nxt;
      res.next_pc        = nxt;
      res.access_kind    = kind;
      res.access_size    = size;
      res.access_address = addr;
      res.store_data     = data;
      if (kind == AccRead) begin
        ld_pend_d = 1'b1;
        ld_tgt_d  = rd;
        ld_fmt_d  = fmt;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= StartReset;
      ld_pend_q   <= 1'b0;
      ld_tgt_q    <= '0;
      ld_fmt_q    <= FmtLw;
      rf_valid_q  <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd1_q      <= 1'b0;
      fwd2_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        pc_q <= start_address_i;
      end else if (s1_fire) begin
        pc_q <= pc_d;
      end
      if (s1_fire) begin
        ld_pend_q <= ld_pend_d;
        ld_tgt_q  <= ld_tgt_d;
        ld_fmt_q  <= ld_fmt_d;
        if (wb_en) begin
          rf_valid_q[wb_addr] <= 1'b1;
        end
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        fwd1_q     <= s1_fire && wb_en && (wb_addr == in_rs1);
        fwd2_q     <= s1_fire && wb_en && (wb_addr == in_rs2);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q  <= item_kind_i;
      s1_inst_q  <= instruction_word_i;
      s1_ldata_q <= load_data_i;
      fwdv_q     <= wb_data;
    end
    if (s1_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign next_pc_o        = out_q.next_pc;
  assign access_kind_o    = out_q.access_kind;
  assign access_size_o    = out_q.access_size;
  assign access_address_o = out_q.access_address;
  assign store_data_o     = out_q.store_data;
  assign fault_o          = out_q.fault;

  // Checks
  a_fault_no_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o |-> access_kind_o == AccNone)
    else $error("fault beat carries a memory access");

  a_load_sets_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !res.fault && res.access_kind == AccRead |=> ld_pend_q)
    else $error("issued load did not mark pending");

  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && wb_en |-> wb_addr != '0)
    else $error("write-back to x0");

  a_fault_holds_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && res.fault && !cfg_valid_i |=> pc_q == $past(pc_q))
    else $error("fault changed the program counter");

endmodule

@@ rtl/rv64x_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rv64x_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, hold while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/sv/rv64i_subset_execute_checker.sv @@
// Checker for the RV64I subset execute block: predicts every result beat and compares it.
`timescale 1ns / 1ps
module rv64i_subset_execute_checker
  import rv64x_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [63:0] start_address_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        item_kind_i,
  input  logic [31:0] instruction_word_i,
  input  logic [63:0] load_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] next_pc_i,
  input  logic [1:0]  access_kind_i,
  input  logic [1:0]  access_size_i,
  input  logic [63:0] access_address_i,
  input  logic [63:0] store_data_i,
  input  logic        fault_i,
  output int          error_count_o,
  output int          pending_count_o,
  output int          result_count_o
);

  logic [63:0] gpr_q [RegCount];
  logic [63:0] pc_q;
  logic        load_busy_q;
  logic [4:0]  load_rd_q;
  logic [1:0]  load_fmt_q;
  result_t     exp_results_q [$];

  function automatic logic [63:0] sext(input logic [63:0] v, input int bits);
    logic [63:0] m;
    m = 64'd1 << (bits - 1);
    v = v & ((64'd1 << bits) - 1);
    return (v ^ m) - m;
  endfunction

  function automatic logic [63:0] sra(input logic [63:0] v, input int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [63:0] gpr(input logic [4:0] idx);
    return (idx == 5'd0) ? 64'd0 : gpr_q[idx];
  endfunction

  // Execute one item against the shadow state and return its result beat.
  function automatic result_t execute_item(input logic kind, input logic [31:0] w,
                                           input logic [63:0] ld);
    result_t r;
    logic [6:0] opc;
    logic [4:0] rd;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [63:0] a, b, immi, nxt, val, addr, data, bi, ji;
    logic [1:0] acc, sz, fmt;
    logic ok, wr, take;
    int sh;
    r = '0;
    r.next_pc = pc_q;
    r.fault = 1'b1;
    opc = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
    a = gpr(w[19:15]); b = gpr(w[24:20]);
    immi = sext(64'(w[31:20]), 12);
    nxt = pc_q + 64'd4; val = '0; addr = '0; data = '0;
    acc = AccNone; sz = 2'd0; fmt = FmtLw; ok = 1'b1; wr = 1'b0; take = 1'b0;
    if (kind == ItemLoad) begin
      if (!load_busy_q) return r;
      case (load_fmt_q)
        FmtLw:   val = sx32(ld[31:0]);
        FmtLbu:  val = {56'd0, ld[7:0]};
        default: val = ld;
      endcase
      if (load_rd_q != 5'd0) gpr_q[load_rd_q] = val;
      load_busy_q = 1'b0;
      r.fault = 1'b0;
      return r;
    end
    if (load_busy_q) return r;
    case (opc)
      OpcLui: begin
        wr = 1'b1; val = sx32({w[31:12], 12'd0});
      end
      OpcJal: begin
        ji = {43'd0, w[31], w[19:12], w[20], w[30:21], 1'b0};
        wr = 1'b1; val = pc_q + 64'd4; nxt = pc_q + sext(ji, 21);
      end
      OpcJalr: begin
        if (f3 != 3'd0) ok = 1'b0;
        else begin
          wr = 1'b1; val = pc_q + 64'd4; nxt = (a + immi) & ~64'd1;
        end
      end
      OpcBranch: begin
        bi = {51'd0, w[31], w[7], w[30:25], w[11:8], 1'b0};
        case (f3)
          3'd0: take = (a == b);
          3'd1: take = (a != b);
          3'd5: take = ($signed(a) >= $signed(b));
          3'd6: take = (a < b);
          3'd7: take = (a >= b);
          default: ok = 1'b0;
        endcase
        if (ok && take) nxt = pc_q + sext(bi, 13);
      end
      OpcLoad: begin
        case (f3)
          3'd2: begin fmt = FmtLw; sz = 2'd2; end
          3'd3: begin fmt = FmtLd; sz = 2'd3; end
          3'd4: begin fmt = FmtLbu; sz = 2'd0; end
          default: ok = 1'b0;
        endcase
        acc = AccRead; addr = a + immi;
      end
      OpcStore: begin
        if (f3 > 3'd3) ok = 1'b0;
        else begin
          acc = AccWrite; sz = f3[1:0]; data = b;
          addr = a + sext(64'({w[31:25], w[11:7]}), 12);
        end
      end
      OpcOpImm: begin
        sh = int'(w[25:20]);
        wr = 1'b1;
        case (f3)
          3'd0: val = a + immi;
          3'd1: if (w[31:26] != 6'd0) ok = 1'b0; else val = a << sh;
          3'd2: val = ($signed(a) < $signed(immi)) ? 64'd1 : 64'd0;
          3'd3: val = (a < immi) ? 64'd1 : 64'd0;
          3'd4: val = a ^ immi;
          3'd5: begin
            if (w[31:26] == 6'd0) val = a >> sh;
            else if (w[31:26] == F6Sra) val = sra(a, sh);
            else ok = 1'b0;
          end
          3'd6: val = a | immi;
          default: val = a & immi;
        endcase
      end
      OpcOp: begin
        wr = 1'b1;
        if (f7 != F7Base) ok = 1'b0;
        else begin
          case (f3)
            3'd0: val = a + b;
            3'd3: val = (a < b) ? 64'd1 : 64'd0;
            3'd4: val = a ^ b;
            3'd6: val = a | b;
            3'd7: val = a & b;
            default: ok = 1'b0;
          endcase
        end
      end
      OpcImm32, OpcOp32: begin
        wr = 1'b1;
        sh = (opc == OpcImm32) ? int'(w[24:20]) : int'(b[4:0]);
        if (f3 == 3'd0) begin
          if (opc == OpcImm32) val = sx32(32'(a + immi));
          else if (f7 == F7Base) val = sx32(32'(a + b));
          else if (f7 == F7Alt) val = sx32(32'(a - b));
          else ok = 1'b0;
        end else if (f3 == 3'd1 && f7 == F7Base) begin
          val = sx32(32'(a << sh));
        end else if (f3 == 3'd5 && f7 == F7Base) begin
          val = sx32(32'({32'd0, a[31:0]} >> sh));
        end else if (f3 == 3'd5 && f7 == F7Alt) begin
          val = sx32(32'(sra(sx32(a[31:0]), sh)));
        end else begin
          ok = 1'b0;
        end
      end
      default: ok = 1'b0;
    endcase
    if (!ok) return r;
    if (wr && rd != 5'd0) gpr_q[rd] = val;
    if (acc == AccRead) begin
      load_busy_q = 1'b1; load_rd_q = rd; load_fmt_q = fmt;
    end
    pc_q = nxt;
    r.next_pc = nxt; r.access_kind = acc; r.access_size = sz;
    r.access_address = addr; r.store_data = data; r.fault = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    error_count_o++;
  endtask

  assign pending_count_o = exp_results_q.size();

  // Track configuration, predict on input beats, compare on output beats.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) gpr_q[i] = '0;
      pc_q = StartReset;
      load_busy_q = 1'b0; load_rd_q = '0; load_fmt_q = FmtLw;
      exp_results_q.delete();
      error_count_o = 0;
      result_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        result_count_o++;
        if (exp_results_q.size() == 0) begin
          $display("%0t: result beat with nothing expected", $realtime);
          error_count_o++;
        end else begin
          want = exp_results_q.pop_front();
          if (next_pc_i !== want.next_pc) report_mismatch("next_pc", next_pc_i, want.next_pc);
          if (access_kind_i !== want.access_kind)
            report_mismatch("access_kind", 64'(access_kind_i), 64'(want.access_kind));
          if (access_size_i !== want.access_size)
            report_mismatch("access_size", 64'(access_size_i), 64'(want.access_size));
          if (access_address_i !== want.access_address)
            report_mismatch("access_address", access_address_i, want.access_address);
          if (store_data_i !== want.store_data)
            report_mismatch("store_data", store_data_i, want.store_data);
          if (fault_i !== want.fault) report_mismatch("fault", 64'(fault_i), 64'(want.fault));
        end
      end
      if (cfg_valid_i && cfg_ready_i) pc_q = start_address_i;
      if (in_valid_i && in_ready_i)
        exp_results_q.push_back(execute_item(item_kind_i, instruction_word_i, load_data_i));
    end
  end

endmodule

@@ tb/sv/rv64i_subset_execute_top_tb.sv @@
// Testbench top for the RV64I subset execute block: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module rv64i_subset_execute_top_tb;
  import rv64x_pkg::*;

  localparam int StallLimit = 5000;

  logic        clk, rst_n;
  logic        cfg_valid, cfg_ready;
  logic [63:0] start_address;
  logic        in_valid, in_ready, item_kind;
  logic [31:0] instruction_word;
  logic [63:0] load_data;
  logic        out_valid, out_ready;
  logic [63:0] next_pc, access_address, store_data;
  logic [1:0]  access_kind, access_size;
  logic        fault;
  int          error_count, pending_count, result_count;
  int          send_idle_pct, recv_stall_pct;
  bit          hold_off;
  int          quiet_cycles;
  int          item_count;
  bit          load_open;

  rv64i_subset_execute_top i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .start_address_i(start_address),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .item_kind_i(item_kind),
    .instruction_word_i(instruction_word), .load_data_i(load_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .next_pc_o(next_pc),
    .access_kind_o(access_kind), .access_size_o(access_size),
    .access_address_o(access_address), .store_data_o(store_data), .fault_o(fault)
  );

  rv64i_subset_execute_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .start_address_i(start_address),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .item_kind_i(item_kind),
    .instruction_word_i(instruction_word), .load_data_i(load_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .next_pc_i(next_pc),
    .access_kind_i(access_kind), .access_size_i(access_size),
    .access_address_i(access_address), .store_data_i(store_data), .fault_i(fault),
    .error_count_o(error_count), .pending_count_o(pending_count),
    .result_count_o(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Pace the receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (rst_n) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: watchdog expired", $realtime);
      $display("** rv64i_subset_execute_top: FAILED **");
      $finish;
    end
  end

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom_range(7));
  endfunction

  function automatic logic [31:0] imm12();
    case ($urandom_range(3))
      0: return 32'h7ff;
      1: return 32'h800;
      default: return 32'($urandom_range(4095));
    endcase
  endfunction

  // Build a random instruction, mostly well-formed with random operands.
  function automatic logic [31:0] random_word();
    logic [31:0] w, im;
    logic [4:0] rd, r1, r2;
    logic [2:0] f3;
    rd = pick_reg(); r1 = pick_reg(); r2 = pick_reg(); im = imm12();
    f3 = 3'($urandom_range(7));
    case ($urandom_range(13))
      0: w = {20'($urandom_range(32'hfffff)), rd, OpcLui};
      1: w = {$urandom_range(1) ? 20'($urandom) : 20'($urandom_range(15) << 1),
              rd, OpcJal};
      2: w = {im[11:0], r1, 3'd0, rd, OpcJalr};
      3: w = {7'($urandom), r2, r1, f3, 5'($urandom), OpcBranch};
      4: w = {im[11:0], r1, 3'($urandom_range(2, 4)), rd, OpcLoad};
      5: w = {im[11:5], r2, r1, 3'($urandom_range(3)), im[4:0], OpcStore};
      6, 7: begin
        if (f3 == 3'd1) im = {26'd0, 6'($urandom)};
        else if (f3 == 3'd5) im = {20'd0, $urandom_range(1) ? F6Sra : 6'd0, 6'($urandom)};
        w = {im[11:0], r1, f3, rd, OpcOpImm};
      end
      8, 9: w = {F7Base, r2, r1, f3, rd, OpcOp};
      10: w = {($urandom_range(1) ? F7Alt : F7Base), 5'($urandom), r1, f3, rd, OpcImm32};
      11: w = {($urandom_range(1) ? F7Alt : F7Base), r2, r1, f3, rd, OpcOp32};
      12: w = {im[11:0], r1, 3'd0, rd, OpcImm32};
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Offer one beat and hold it until it is taken.
  task automatic send_item(input logic kind, input logic [31:0] w, input logic [63:0] ld);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    item_kind <= kind;
    instruction_word <= w;
    load_data <= ld;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == ItemLoad) load_open = 1'b0;
    else if (w[6:0] == OpcLoad && w[14:12] inside {3'd2, 3'd3, 3'd4}) load_open = 1'b1;
    item_count++;
  endtask

  task automatic send_inst(input logic [31:0] w);
    send_item(ItemInst, w, 64'($urandom) << 32 | 64'($urandom));
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start(input logic [63:0] addr);
    cfg_valid <= 1'b1;
    start_address <= addr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    load_open = 1'b0;
  endtask

  // Random traffic: responses follow loads, with some stray and broken sequences.
  task automatic random_phase(input int count);
    logic [63:0] d;
    repeat (count) begin
      d = {32'($urandom), 32'($urandom)};
      if (load_open && $urandom_range(9) != 0) send_item(ItemLoad, $urandom, d);
      else if ($urandom_range(24) == 0) send_item(ItemLoad, $urandom, d);
      else send_inst(random_word());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0; start_address = '0;
    in_valid = 1'b0; item_kind = 1'b0; instruction_word = '0; load_data = '0;
    out_ready = 1'b0; hold_off = 1'b0; quiet_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0; item_count = 0; load_open = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a selection of operations, extreme fields and several fault cases.
    send_inst({20'h80000, 5'd1, OpcLui});
    send_inst({20'hfffff, 5'd2, OpcLui});
    send_inst({12'h7ff, 5'd1, 3'd0, 5'd3, OpcOpImm});
    send_inst({12'h800, 5'd2, 3'd0, 5'd4, OpcOpImm});
    send_inst({12'hfff, 5'd4, 3'd3, 5'd5, OpcOpImm});
    send_inst({12'hfff, 5'd4, 3'd2, 5'd5, OpcOpImm});
    send_inst({6'h10, 6'd63, 5'd2, 3'd5, 5'd6, OpcOpImm});
    send_inst({6'h01, 6'd1, 5'd2, 3'd1, 5'd6, OpcOpImm});
    send_inst({F7Alt, 5'd31, 5'd1, 3'd5, 5'd7, OpcImm32});
    send_inst({F7Alt, 5'd3, 5'd1, 3'd0, 5'd7, OpcOp32});
    send_inst({F7Alt, 5'd3, 5'd1, 3'd5, 5'd7, OpcOp32});
    send_inst({12'hffc, 5'd3, 3'd3, 5'd8, OpcLoad});
    send_inst(32'h0000_0013);
    send_item(ItemLoad, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_item(ItemLoad, 32'h0, 64'h0);
    send_inst({12'h000, 5'd3, 3'd4, 5'd0, OpcLoad});
    send_item(ItemLoad, 32'h0, 64'h1234_5678_8000_00ff);
    send_inst({12'h001, 5'd3, 3'd2, 5'd9, OpcLoad});
    send_item(ItemLoad, 32'h0, 64'h0000_0000_8000_0000);
    send_inst({7'h7f, 5'd8, 5'd3, 3'd3, 5'h1f, OpcStore});
    send_inst({7'h7f, 5'd1, 5'd2, 3'd6, 5'h1f, OpcBranch});
    send_inst({1'b1, 10'h3ff, 1'b1, 8'hff, 5'd10, OpcJal});
    send_inst({12'h801, 5'd2, 3'd0, 5'd11, OpcJalr});
    send_inst({12'h000, 5'd0, 3'd1, 5'd0, OpcJalr});
    send_inst(32'hffff_ffff);
    drain_and_idle();

    // Random phases with several start addresses and pacing profiles.
    write_start(64'hffff_ffff_ffff_fffc);
    random_phase(250);
    drain_and_idle();
    write_start(64'd0);
    send_idle_pct = 77;
    random_phase(200);
    drain_and_idle();
    write_start({32'($urandom), 32'($urandom)});
    send_idle_pct = 0; recv_stall_pct = 77;
    random_phase(200);
    drain_and_idle();
    write_start(StartReset);
    send_idle_pct = 31; recv_stall_pct = 31;
    random_phase(200);

    // Back up the block: hold the receiver off while the sender keeps offering.
    send_idle_pct = 0; recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(175);
    join
    drain_and_idle();

    $display("Ran %0d items and checked %0d result beats over five start addresses,",
             item_count, result_count);
    $display("with idle sender, stalled receiver, mixed pacing and a long output hold-off.");
    if (error_count == 0) begin
      $display("** rv64i_subset_execute_top: PASSED **");
    end else begin
      $display("** rv64i_subset_execute_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rv64x_pkg.sv
rtl/rv64x_ram.sv
rtl/rv64i_subset_execute_top.sv
tb/sv/rv64i_subset_execute_checker.sv
tb/sv/rv64i_subset_execute_top_tb.sv
